### hw/rtl/owrm_pkg.sv
// Shared types and constants for the overlapping-window RMS meter.
// No dependencies; every other file but owrm_ram uses this package.
package owrm_pkg;

  // Default sizes of the window and channel stores
  localparam int unsigned MAX_WINDOWS_DEF  = 64;
  localparam int unsigned MAX_CHANNELS_DEF = 8;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CHANNEL_W  = 3;
  localparam int unsigned LOUD_W     = 27;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned CNT_W      = 18;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned NWIN_CFG_W = 7;
  localparam int unsigned NCH_CFG_W  = 4;
  localparam int unsigned NW_W       = 9;
  localparam int unsigned NCH_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [LEN_W-1:0]  LEN_MAX  = 17'd65536;
  localparam logic [LOUD_W-1:0] LOUD_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MIN  = {1'b1, {(CNT_W-1){1'b0}}};

  // Register reset values
  localparam logic [LEN_W-1:0]      WIN_RST     = 17'd19200;
  localparam logic [LEN_W-1:0]      HOP_RST     = 17'd4800;
  localparam logic [NWIN_CFG_W-1:0] NWIN_RST    = 7'd4;
  localparam logic [NCH_CFG_W-1:0]  NCH_RST     = 4'd2;
  localparam logic                  PARTIAL_RST = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 3'd0,
    CFG_HOP     = 3'd1,
    CFG_NWIN    = 3'd2,
    CFG_NCH     = 3'd3,
    CFG_PARTIAL = 3'd4
  } cfg_idx_e;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [LEN_W-1:0] win;
    logic [LEN_W-1:0] hop;
    logic [NW_W-1:0]  nwin;
    logic [NCH_W-1:0] nch;
    logic             partial;
  } cfg_t;

  // One queued sample
  typedef struct packed {
    logic [SQ_W-1:0]      sq;
    logic [CHANNEL_W-1:0] ch;
    logic                 close;
  } item_t;

  // Back-end status toward front end and top
  typedef struct packed {
    logic clearing;
    logic idle;
  } status_t;

  // Back-end sequencer states
  typedef enum logic [12:0] {
    ST_CLR    = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_ACC    = 13'b0000000000100,
    ST_P_RD   = 13'b0000000001000,
    ST_P_CHK  = 13'b0000000010000,
    ST_W_RD   = 13'b0000000100000,
    ST_W_CHK  = 13'b0000001000000,
    ST_M_RD   = 13'b0000010000000,
    ST_M_GO   = 13'b0000100000000,
    ST_M_WAIT = 13'b0001000000000,
    ST_S_GO   = 13'b0010000000000,
    ST_S_WAIT = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_e;

endpackage

### hw/rtl/overlapping_window_rms_meter_core.sv
// Overlapping-window RMS loudness meter. Each accepted sample walks the
// window counters and accumulators, one window per cycle through the energy
// memory port. A sample that closes a frame adds a counter pass over the
// windows and, for the running-mean report (when partial reporting is on)
// and for each window that completes, a serial divide per channel mean and
// a serial square root. After reset and after every register write a
// clearing pass over all MAX_CHANNELS * MAX_WINDOWS energy entries (512 by
// default) zeroes the energy memory; input stalls meanwhile. A two-entry
// queue sits between the front end and the sequencer, and a result register
// lets the next samples enter while a result waits. Samples of a channel at
// or beyond num_channels are dropped without a result.
module overlapping_window_rms_meter_core #(
  parameter int unsigned MaxWindows  = owrm_pkg::MAX_WINDOWS_DEF,
  parameter int unsigned MaxChannels = owrm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [owrm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [owrm_pkg::CHANNEL_W-1:0]       channel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [owrm_pkg::LOUD_W-1:0]          loudness_o,
  output logic                                 window_done_o,
  input  logic                                 cfg_we_i,
  input  logic [owrm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [owrm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import owrm_pkg::*;

  logic [LEN_W-1:0]      win_q, hop_q;
  logic [NWIN_CFG_W-1:0] nwin_q;
  logic [NCH_CFG_W-1:0]  nch_q;
  logic                  part_q, restart_q;
  cfg_t                  cfg;
  status_t               bstat;
  logic                  head_valid, pop;
  item_t                 head;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WIN_RST;
      hop_q     <= HOP_RST;
      nwin_q    <= NWIN_RST;
      nch_q     <= NCH_RST;
      part_q    <= PARTIAL_RST;
      restart_q <= 1'b0;
    end else begin
      restart_q <= cfg_we_i && (cfg_index_i <= CFG_PARTIAL);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_WINDOW:  win_q  <= cfg_data_i[LEN_W-1:0];
          CFG_HOP:     hop_q  <= cfg_data_i[LEN_W-1:0];
          CFG_NWIN:    nwin_q <= cfg_data_i[NWIN_CFG_W-1:0];
          CFG_NCH:     nch_q  <= cfg_data_i[NCH_CFG_W-1:0];
          CFG_PARTIAL: part_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Clamp registers to their usable ranges
  always_comb begin
    cfg.win  = (win_q == '0) ? LEN_W'(1) : ((win_q > LEN_MAX) ? LEN_MAX : win_q);
    cfg.hop  = (hop_q == '0) ? LEN_W'(1) : ((hop_q > LEN_MAX) ? LEN_MAX : hop_q);
    cfg.nwin = (nwin_q == '0) ? NW_W'(1) :
               ((NW_W'(nwin_q) > NW_W'(MaxWindows)) ? NW_W'(MaxWindows) : NW_W'(nwin_q));
    cfg.nch  = (nch_q == '0) ? NCH_W'(1) :
               ((NCH_W'(nch_q) > NCH_W'(MaxChannels)) ? NCH_W'(MaxChannels)
                                                      : NCH_W'(nch_q));
    cfg.partial = part_q;
  end

  owrm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_i, .channel_i,
    .nch_i(cfg.nch), .busy_i(bstat.clearing || restart_q),
    .head_valid_o(head_valid), .head_o(head), .pop_i(pop)
  );

  owrm_back #(.MaxWindows(MaxWindows), .MaxChannels(MaxChannels)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .restart_i(restart_q),
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop), .status_o(bstat),
    .out_valid_o, .out_stall_i, .loudness_o, .window_done_o
  );

  // A register write blocks input until the clearing pass is over
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i <= CFG_PARTIAL)) |=> in_stall_o)
    else $error("input not stalled after register write");

  // A restart always enters the clearing pass
  a_restart_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_q |=> bstat.clearing)
    else $error("restart did not start clearing");

  // The sequencer only pops the queue while it holds a sample
  a_idle_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

### hw/rtl/owrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module owrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read, one port each
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/owrm_front.sv
// Front end: accepts samples, drops foreign channels, squares, queues.
// Depends on owrm_pkg.
module owrm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [owrm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [owrm_pkg::CHANNEL_W-1:0]      channel_i,
  input  logic [owrm_pkg::NCH_W-1:0]          nch_i,
  input  logic                                busy_i,
  output logic                                head_valid_o,
  output owrm_pkg::item_t                     head_o,
  input  logic                                pop_i
);
  import owrm_pkg::*;

  logic [SAMPLE_W-1:0] mag;
  logic [NCH_W-1:0]    ch_ext;
  item_t               item;
  logic                accept, push, keep;
  item_t               q_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;

  // Classify and square the incoming sample
  always_comb begin
    mag        = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
    ch_ext     = NCH_W'(channel_i);
    keep       = ch_ext < nch_i;
    item.sq    = SQ_W'(mag) * SQ_W'(mag);
    item.ch    = channel_i;
    item.close = ch_ext == (nch_i - NCH_W'(1));
  end

  assign in_stall_o   = busy_i || (cnt_q == 2'd2);
  assign accept       = in_valid_i && !in_stall_o;
  assign push         = accept && keep;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = q_q[rd_ptr_q];

  // Store queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

### hw/rtl/owrm_div.sv
// Restoring divider, one quotient bit per cycle, for channel means.
// Depends on owrm_pkg.
module owrm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [owrm_pkg::SUM_W-1:0]   dividend_i,
  input  logic [owrm_pkg::LEN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [owrm_pkg::SUM_W-1:0]   quot_o
);
  import owrm_pkg::*;

  localparam int unsigned CntW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quot_q;
  logic [LEN_W-1:0] rem_q, dvs_q;
  logic [LEN_W:0]   rem_sh;
  logic             ge;
  logic [CntW-1:0]  cnt_q;
  logic             run_q, done_q;

  assign rem_sh = {rem_q, quot_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[SUM_W-2:0], ge};
      rem_q  <= ge ? LEN_W'(rem_sh - {1'b0, dvs_q}) : LEN_W'(rem_sh);
    end
  end

  // Count iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(SUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hw/rtl/owrm_sqrt.sv
// Integer square root, one result bit per cycle (digit-by-digit).
// Depends on owrm_pkg.
module owrm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [owrm_pkg::SUM_W-1:0] radicand_i,
  output logic                       done_o,
  output logic [owrm_pkg::SUM_W-1:0] root_o
);
  import owrm_pkg::*;

  logic [SUM_W-1:0] x_q, res_q, bit_q, trial;
  logic             run_q, done_q;

  assign trial = res_q + bit_q;

  // Resolve one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      res_q <= '0;
      bit_q <= {2'b01, {(SUM_W-2){1'b0}}};
    end else if (run_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Run until the lowest bit pair is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && bit_q[0];
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

### hw/rtl/owrm_back.sv
// Back end: window accumulation, frame close, means, root, result register.
// Depends on owrm_pkg, owrm_ram, owrm_div and owrm_sqrt.
module owrm_back #(
  parameter int unsigned MaxWindows  = owrm_pkg::MAX_WINDOWS_DEF,
  parameter int unsigned MaxChannels = owrm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  owrm_pkg::cfg_t              cfg_i,
  input  logic                        restart_i,
  input  logic                        head_valid_i,
  input  owrm_pkg::item_t             head_i,
  output logic                        pop_o,
  output owrm_pkg::status_t           status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [owrm_pkg::LOUD_W-1:0] loudness_o,
  output logic                        window_done_o
);
  import owrm_pkg::*;

  localparam int unsigned EDepth = MaxWindows * MaxChannels;
  localparam int unsigned WinAw  = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;
  localparam int unsigned EAw    = (EDepth > 1) ? $clog2(EDepth) : 1;
  localparam int unsigned ClrW   = $clog2(EDepth + 1);

  function automatic logic [EAw-1:0] ea(input logic [NCH_W-1:0] c,
                                        input logic [NW_W-1:0] w);
    return EAw'(32'(c) * 32'(MaxWindows) + 32'(w));
  endfunction

  state_e           state_q, state_d;
  logic [ClrW-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0] start_q, start_d;
  logic [NW_W-1:0]  issue_q, issue_d, pend_idx_q, pend_idx_d, widx_q, widx_d;
  logic             pend_q, pend_d;
  logic [NCH_W-1:0] ch_idx_q, ch_idx_d;
  logic [LEN_W-1:0] div_q, div_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             wmode_q, wmode_d, done_q, done_d, partial_q, partial_d;
  logic [LOUD_W-1:0] loud_q, loud_d, out_loud_q, out_loud_d;
  logic [EAw-1:0]   eaddr_q, eaddr_d;
  logic             out_valid_q, out_valid_d, out_done_q, out_done_d;

  logic             c_we, e_we;
  logic [WinAw-1:0] c_waddr, c_raddr;
  logic [CNT_W-1:0] c_wdata, c_rdata;
  logic [EAw-1:0]   e_waddr, e_raddr;
  logic [SUM_W-1:0] e_wdata, e_rdata;
  logic             div_start, div_done, sqrt_start, sqrt_done;
  logic [SUM_W-1:0] quot, root;
  logic [NCH_W-1:0] ch5;
  logic [CNT_W:0]   st_next;
  logic signed [CNT_W:0] inc, win_s;

  owrm_ram #(.Width(CNT_W), .Depth(MaxWindows)) u_cnt_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  owrm_ram #(.Width(SUM_W), .Depth(EDepth)) u_energy_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  owrm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(e_rdata),
    .divisor_i(div_q), .done_o(div_done), .quot_o(quot)
  );

  owrm_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .radicand_i({sum_q[SUM_W-3:0], 2'b00}),
    .done_o(sqrt_done), .root_o(root)
  );

  assign ch5     = NCH_W'(head_i.ch);
  assign st_next = {start_q[CNT_W-1], start_q} - {2'b00, cfg_i.hop};
  assign inc     = $signed({c_rdata[CNT_W-1], c_rdata}) + $signed((CNT_W+1)'(1));
  assign win_s   = $signed({2'b00, cfg_i.win});

  // Sequence one queued sample through accumulate, close and report
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    start_d     = start_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    widx_d      = widx_q;
    ch_idx_d    = ch_idx_q;
    div_d       = div_q;
    sum_d       = sum_q;
    wmode_d     = wmode_q;
    done_d      = done_q;
    partial_d   = partial_q;
    loud_d      = loud_q;
    eaddr_d     = eaddr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_loud_d  = out_loud_q;
    out_done_d  = out_done_q;
    c_we        = 1'b0;
    c_waddr     = '0;
    c_wdata     = '0;
    c_raddr     = '0;
    e_we        = 1'b0;
    e_waddr     = '0;
    e_wdata     = '0;
    e_raddr     = '0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    pop_o       = 1'b0;

    unique case (state_q)
      // Zero the energy store and load staggered window counts
      ST_CLR: begin
        e_we    = 1'b1;
        e_waddr = EAw'(clr_q);
        if (clr_q < ClrW'(MaxWindows)) begin
          c_we    = 1'b1;
          c_waddr = WinAw'(clr_q);
          c_wdata = start_q;
          start_d = (st_next[CNT_W] && !st_next[CNT_W-1]) ? CNT_MIN : st_next[CNT_W-1:0];
        end
        clr_d = clr_q + ClrW'(1);
        if (clr_q == ClrW'(EDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          issue_d = '0;
          pend_d  = 1'b0;
          done_d  = 1'b0;
          state_d = ST_ACC;
        end
      end
      // Add the square to every running window of this channel
      ST_ACC: begin
        if (pend_q && !c_rdata[CNT_W-1]) begin
          e_we    = 1'b1;
          e_waddr = ea(ch5, pend_idx_q);
          e_wdata = e_rdata + SUM_W'(head_i.sq);
        end
        if (issue_q != cfg_i.nwin) begin
          c_raddr    = WinAw'(issue_q);
          e_raddr    = ea(ch5, issue_q);
          issue_d    = issue_q + NW_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = issue_q;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (head_i.close) begin
              widx_d  = '0;
              state_d = partial_q ? ST_P_RD : ST_W_RD;
            end else begin
              pop_o   = 1'b1;
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_P_RD: begin
        c_raddr = '0;
        state_d = ST_P_CHK;
      end
      // Running mean of window 0 divides by its sample count
      ST_P_CHK: begin
        div_d    = c_rdata[CNT_W-1] ? LEN_W'(1) : LEN_W'(c_rdata) + LEN_W'(1);
        ch_idx_d = '0;
        sum_d    = '0;
        wmode_d  = 1'b0;
        state_d  = ST_M_RD;
      end
      ST_W_RD: begin
        if (widx_q == cfg_i.nwin) begin
          state_d = ST_OUT;
        end else begin
          c_raddr = WinAw'(widx_q);
          state_d = ST_W_CHK;
        end
      end
      // Advance a window count; a full window starts its mean pass
      ST_W_CHK: begin
        c_we    = 1'b1;
        c_waddr = WinAw'(widx_q);
        if (inc >= win_s) begin
          c_wdata   = '0;
          done_d    = 1'b1;
          partial_d = 1'b0;
          div_d     = cfg_i.win;
          ch_idx_d  = '0;
          sum_d     = '0;
          wmode_d   = 1'b1;
          state_d   = ST_M_RD;
        end else begin
          c_wdata = inc[CNT_W-1:0];
          widx_d  = widx_q + NW_W'(1);
          state_d = ST_W_RD;
        end
      end
      ST_M_RD: begin
        e_raddr = ea(ch_idx_q, widx_q);
        eaddr_d = ea(ch_idx_q, widx_q);
        state_d = ST_M_GO;
      end
      // Divide one channel sum; drop it when its window is closing
      ST_M_GO: begin
        div_start = 1'b1;
        if (wmode_q) begin
          e_we    = 1'b1;
          e_waddr = eaddr_q;
        end
        state_d = ST_M_WAIT;
      end
      ST_M_WAIT: begin
        if (div_done) begin
          sum_d    = sum_q + quot;
          ch_idx_d = ch_idx_q + NCH_W'(1);
          state_d  = (ch_idx_q + NCH_W'(1) == cfg_i.nch) ? ST_S_GO : ST_M_RD;
        end
      end
      ST_S_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_S_WAIT;
      end
      ST_S_WAIT: begin
        if (sqrt_done) begin
          loud_d = (root > SUM_W'(LOUD_MAX)) ? LOUD_MAX : root[LOUD_W-1:0];
          if (wmode_q) begin
            widx_d = widx_q + NW_W'(1);
          end
          state_d = ST_W_RD;
        end
      end
      // Hand the frame result to the output register
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_loud_d  = loud_q;
          out_done_d  = done_q;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase

    // Restart metering after a register write
    if (restart_i) begin
      state_d   = ST_CLR;
      clr_d     = '0;
      start_d   = '0;
      partial_d = cfg_i.partial;
      if (!cfg_i.partial) begin
        loud_d = '0;
      end
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    widx_q     <= widx_d;
    ch_idx_q   <= ch_idx_d;
    div_q      <= div_d;
    sum_q      <= sum_d;
    wmode_q    <= wmode_d;
    eaddr_q    <= eaddr_d;
    out_loud_q <= out_loud_d;
    out_done_q <= out_done_d;
  end

  // Hold control and metering state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      start_q     <= '0;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
      partial_q   <= PARTIAL_RST;
      loud_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      start_q     <= start_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
      partial_q   <= partial_d;
      loud_q      <= loud_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.clearing = state_q == ST_CLR;
  assign status_o.idle     = state_q == ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign loudness_o        = out_loud_q;
  assign window_done_o     = out_done_q;

endmodule
